>>> hw/rtl/rgb_to_hsv_converter_assert.svh
// ----------------------------------------------------------------------------
// rgb to hsv converter assertion macros
// shared property forms for the converter's concurrent checks
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RGBHSV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbhsv check failed");

// antecedent implies consequent in the following cycle
`define RGBHSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbhsv sequence check failed");

`endif

>>> hw/rtl/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// word types, widths and sector codes for the rgb to hsv converter
// ----------------------------------------------------------------------------
`default_nettype none

package rgbhsv_pkg;

    localparam int CHANNEL_BITS  = 8;
    localparam int HUE_FRAC_BITS = 8;
    localparam int HUE_BITS      = HUE_FRAC_BITS + 3;
    localparam int HUE_UNIT      = 1 << HUE_FRAC_BITS;
    localparam int HUE_TURN      = 6 * HUE_UNIT;

    // one divider stage per quotient bit, enough for both quotients
    localparam int DIV_QUO_BITS  = (CHANNEL_BITS > HUE_FRAC_BITS + 1) ?
                                   CHANNEL_BITS : HUE_FRAC_BITS + 1;
    localparam int DIV_LATENCY   = DIV_QUO_BITS + 1;

    localparam logic [1:0] SECTOR_RED   = 2'd0;
    localparam logic [1:0] SECTOR_GREEN = 2'd1;
    localparam logic [1:0] SECTOR_BLUE  = 2'd2;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [HUE_BITS-1:0]     hue;
        logic [CHANNEL_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0] value;
    } t_hsv;

    // per-pixel info that rides alongside the dividers
    typedef struct packed {
        logic [1:0]              sector;
        logic                    neg;
        logic [CHANNEL_BITS-1:0] value;
    } t_side;

endpackage

`default_nettype wire

>>> hw/rtl/rgbhsv_front.sv
// ----------------------------------------------------------------------------
// rgbhsv_front
// two stages: max/min and sector pick, then span, difference and numerators
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsv_front (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    input  wire rgbhsv_pkg::t_rgb                       i_pixel,
    output logic                                        o_valid,
    output logic [2*rgbhsv_pkg::CHANNEL_BITS-1:0]       o_num_sat,
    output logic [rgbhsv_pkg::CHANNEL_BITS-1:0]         o_den_sat,
    output logic [rgbhsv_pkg::CHANNEL_BITS+rgbhsv_pkg::HUE_FRAC_BITS-1:0] o_num_hue,
    output logic [rgbhsv_pkg::CHANNEL_BITS-1:0]         o_den_hue,
    output rgbhsv_pkg::t_side                           o_side
);

    localparam int C = rgbhsv_pkg::CHANNEL_BITS;
    localparam int F = rgbhsv_pkg::HUE_FRAC_BITS;

    logic         w_g_ge_b;
    logic [1:0]   w_sector;
    logic [C-1:0] w_max, w_min, w_op_a, w_op_b;

    logic         r_s1_valid;
    logic [1:0]   r_s1_sector;
    logic [C-1:0] r_s1_max, r_s1_min, r_s1_op_a, r_s1_op_b;

    logic [C-1:0]   w_span, w_mag;
    logic           w_neg;
    logic [2*C-1:0] w_num_sat;

    logic             r_s2_valid;
    logic [2*C-1:0]   r_s2_num_sat;
    logic [C-1:0]     r_s2_den_sat;
    logic [C+F-1:0]   r_s2_num_hue;
    logic [C-1:0]     r_s2_den_hue;
    rgbhsv_pkg::t_side r_s2_side;

    // red wins ties over green, green over blue
    always_comb begin
        w_g_ge_b = (i_pixel.green >= i_pixel.blue);
        if (i_pixel.red >= i_pixel.green && i_pixel.red >= i_pixel.blue) begin
            w_sector = rgbhsv_pkg::SECTOR_RED;
            w_max    = i_pixel.red;
            w_op_a   = i_pixel.green;
            w_op_b   = i_pixel.blue;
        end else if (w_g_ge_b) begin
            w_sector = rgbhsv_pkg::SECTOR_GREEN;
            w_max    = i_pixel.green;
            w_op_a   = i_pixel.blue;
            w_op_b   = i_pixel.red;
        end else begin
            w_sector = rgbhsv_pkg::SECTOR_BLUE;
            w_max    = i_pixel.blue;
            w_op_a   = i_pixel.red;
            w_op_b   = i_pixel.green;
        end
        w_min = i_pixel.red;
        if (i_pixel.green < w_min) begin
            w_min = i_pixel.green;
        end
        if (i_pixel.blue < w_min) begin
            w_min = i_pixel.blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_sector <= w_sector;
        r_s1_max    <= w_max;
        r_s1_min    <= w_min;
        r_s1_op_a   <= w_op_a;
        r_s1_op_b   <= w_op_b;
    end

    // saturation numerator is span times full scale: (span << C) - span
    always_comb begin
        w_span    = r_s1_max - r_s1_min;
        w_neg     = (r_s1_op_a < r_s1_op_b);
        w_mag     = w_neg ? (r_s1_op_b - r_s1_op_a) : (r_s1_op_a - r_s1_op_b);
        w_num_sat = {w_span, {C{1'b0}}} - (2*C)'(w_span);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_num_sat      <= w_num_sat;
        r_s2_den_sat      <= r_s1_max;
        r_s2_num_hue      <= {w_mag, {F{1'b0}}};
        r_s2_den_hue      <= w_span;
        r_s2_side.sector  <= r_s1_sector;
        r_s2_side.neg     <= w_neg;
        r_s2_side.value   <= r_s1_max;
    end

    assign o_valid   = r_s2_valid;
    assign o_num_sat = r_s2_num_sat;
    assign o_den_sat = r_s2_den_sat;
    assign o_num_hue = r_s2_num_hue;
    assign o_den_hue = r_s2_den_hue;
    assign o_side    = r_s2_side;

endmodule

`default_nettype wire

>>> hw/rtl/rgbhsv_div.sv
// ----------------------------------------------------------------------------
// rgbhsv_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module rgbhsv_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 8,
    parameter int QUO_W = 9
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_valid,
    output logic [QUO_W-1:0]      o_quo,
    output logic [DEN_W-1:0]      o_rem
);

    // wide enough to hold the divisor shifted up to the top quotient bit
    localparam int W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [QUO_W:0]   r_valid;
    logic [W-1:0]     r_rem [QUO_W+1];
    logic [DEN_W-1:0] r_den [QUO_W+1];
    logic [QUO_W-1:0] r_quo [QUO_W+1];

    // zero divisor only comes with a zero numerator; treat it as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= W'(i_num);
        r_den[0] <= (i_den == '0) ? DEN_W'(1) : i_den;
        r_quo[0] <= '0;
    end

    for (genvar s = 1; s <= QUO_W; s++) begin : g_stage
        localparam int B = QUO_W - s;

        logic [W-1:0]     w_trial;
        logic             w_ge;
        logic [W-1:0]     n_rem;
        logic [QUO_W-1:0] n_quo;

        always_comb begin
            w_trial  = W'(r_den[s-1]) << B;
            w_ge     = (r_rem[s-1] >= w_trial);
            n_rem    = w_ge ? (r_rem[s-1] - w_trial) : r_rem[s-1];
            n_quo    = r_quo[s-1];
            n_quo[B] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else begin
                r_valid[s] <= r_valid[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s] <= n_rem;
            r_den[s] <= r_den[s-1];
            r_quo[s] <= n_quo;
        end
    end

    assign o_valid = r_valid[QUO_W];
    assign o_quo   = r_quo[QUO_W];
    assign o_rem   = r_rem[QUO_W][DEN_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Pixel-rate RGB to HSV conversion. One pixel word is taken every clock
// (busy is never raised) and its HSV word appears on o_hsv with o_valid
// high for one cycle, after it passes two front stages, a ten-stage
// divider pipeline (nine quotient bits plus its input register) and the
// output register. The receiver cannot stall, so it must take every word
// in the cycle that o_valid marks. Hue is counted in 1/1536 of a turn,
// saturation and value in channel codes.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire rgbhsv_pkg::t_rgb i_pixel,
    output logic                  o_valid,
    output rgbhsv_pkg::t_hsv      o_hsv
);

`include "rgb_to_hsv_converter_assert.svh"

    localparam int C   = rgbhsv_pkg::CHANNEL_BITS;
    localparam int F   = rgbhsv_pkg::HUE_FRAC_BITS;
    localparam int H   = rgbhsv_pkg::HUE_BITS;
    localparam int Q   = rgbhsv_pkg::DIV_QUO_BITS;
    localparam int LAT = rgbhsv_pkg::DIV_LATENCY;

    logic              w_fr_valid;
    logic [2*C-1:0]    w_num_sat;
    logic [C-1:0]      w_den_sat;
    logic [C+F-1:0]    w_num_hue;
    logic [C-1:0]      w_den_hue;
    rgbhsv_pkg::t_side w_fr_side;

    logic              w_sv_valid, w_hv_valid;
    logic [Q-1:0]      w_sat_quo, w_hue_quo;
    logic [C-1:0]      w_hue_rem;

    rgbhsv_pkg::t_side r_side [LAT];

    logic signed [H:0] w_base, w_mag, w_frac, w_sum;
    rgbhsv_pkg::t_hsv  n_out;
    rgbhsv_pkg::t_hsv  r_out;
    logic              r_valid;

    assign busy = 1'b0;

    rgbhsv_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (start),
        .i_pixel   (i_pixel),
        .o_valid   (w_fr_valid),
        .o_num_sat (w_num_sat),
        .o_den_sat (w_den_sat),
        .o_num_hue (w_num_hue),
        .o_den_hue (w_den_hue),
        .o_side    (w_fr_side)
    );

    rgbhsv_div #(
        .NUM_W (2*C),
        .DEN_W (C),
        .QUO_W (Q)
    ) u_div_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .i_num   (w_num_sat),
        .i_den   (w_den_sat),
        .o_valid (w_sv_valid),
        .o_quo   (w_sat_quo),
        .o_rem   ()
    );

    rgbhsv_div #(
        .NUM_W (C+F),
        .DEN_W (C),
        .QUO_W (Q)
    ) u_div_hue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .i_num   (w_num_hue),
        .i_den   (w_den_hue),
        .o_valid (w_hv_valid),
        .o_quo   (w_hue_quo),
        .o_rem   (w_hue_rem)
    );

    // sector, sign and value follow the dividers
    always_ff @(posedge i_clk) begin
        r_side[0] <= w_fr_side;
        for (int i = 1; i < LAT; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    // negative fractions round toward minus infinity: -(q + (rem != 0))
    always_comb begin
        unique case (r_side[LAT-1].sector)
            rgbhsv_pkg::SECTOR_RED:   w_base = '0;
            rgbhsv_pkg::SECTOR_GREEN: w_base = (H+1)'(2 * rgbhsv_pkg::HUE_UNIT);
            rgbhsv_pkg::SECTOR_BLUE:  w_base = (H+1)'(4 * rgbhsv_pkg::HUE_UNIT);
            default:                  w_base = '0;
        endcase
        if (r_side[LAT-1].neg) begin
            w_mag  = (H+1)'(w_hue_quo) + (H+1)'(w_hue_rem != '0);
            w_frac = -w_mag;
        end else begin
            w_mag  = (H+1)'(w_hue_quo);
            w_frac = w_mag;
        end
        w_sum = w_base + w_frac;
        if (w_sum[H]) begin
            w_sum = w_sum + (H+1)'(rgbhsv_pkg::HUE_TURN);
        end
        n_out.hue        = w_sum[H-1:0];
        n_out.saturation = w_sat_quo[C-1:0];
        n_out.value      = r_side[LAT-1].value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_hv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_valid = r_valid;
    assign o_hsv   = r_out;

    `RGBHSV_ASSERT_IMPL(a_div_aligned, i_clk, i_rst_n, 1'b1, w_sv_valid == w_hv_valid)
    `RGBHSV_ASSERT_NEXT(a_out_follows_div, i_clk, i_rst_n, w_hv_valid, o_valid)
    `RGBHSV_ASSERT_IMPL(a_hue_in_turn, i_clk, i_rst_n, o_valid, o_hsv.hue < H'(rgbhsv_pkg::HUE_TURN))
    `RGBHSV_ASSERT_IMPL(a_black_no_sat, i_clk, i_rst_n, o_valid && o_hsv.value == '0, o_hsv.saturation == '0 && o_hsv.hue == '0)

endmodule

`default_nettype wire
